[design/ntwa_pkg.sv]
// shared types and codes for the neighbor table with aging
// depends on nothing; used by neighbor_table_with_aging_core
package ntwa_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int ID_BITS_DEF   = 16;
	localparam int TIME_BITS_DEF = 32;

	localparam int FUNC_W  = 3;
	localparam int ID_W    = 16;
	localparam int MAC_W   = 48;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 2;

	// operation codes
	localparam logic [FUNC_W-1:0] F_INSERT    = 3'd0;
	localparam logic [FUNC_W-1:0] F_ERASE_MAC = 3'd1;
	localparam logic [FUNC_W-1:0] F_ERASE_ID  = 3'd2;
	localparam logic [FUNC_W-1:0] F_UPDATE    = 3'd3;
	localparam logic [FUNC_W-1:0] F_LOOKUP    = 3'd4;
	localparam logic [FUNC_W-1:0] F_CLEAR     = 3'd5;
	localparam logic [FUNC_W-1:0] F_FLUSH     = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   node_id;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] contact_time;
		logic              connected;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              present;
	} rsp_t;

endpackage

[design/neighbor_table_with_aging_core.sv]
// neighbor table with mark-and-sweep aging: slot memory, valid flops, scan sequencer
// depends on ntwa_pkg
//
// a transaction scans the slots one per cycle through a memory with a registered read
// port; a hit ends the scan early, else it runs to the last slot; done is registered
// a new transaction is accepted only while idle (not busy), as the single read port serves one scan
// reset: all slots invalid, sequencer idle; slot contents are undefined until written
// the receiver cannot stall: each result is shown for one cycle on done
module neighbor_table_with_aging_core #(
	parameter int ENTRIES   = ntwa_pkg::ENTRIES_DEF,
	parameter int ID_BITS   = ntwa_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = ntwa_pkg::TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ntwa_pkg::req_t req,
	output logic          done,
	output ntwa_pkg::rsp_t rsp
);

	// stored widths: only the low id / time bits take part
	localparam int KEY_W = (ID_BITS < ntwa_pkg::ID_W) ? ID_BITS : ntwa_pkg::ID_W;
	localparam int TW    = (TIME_BITS < ntwa_pkg::TIME_W) ? TIME_BITS : ntwa_pkg::TIME_W;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	// slot word layout: {id, mac, time, connected}
	localparam int CONN_LSB = 0;
	localparam int TIME_LSB = 1;
	localparam int MAC_LSB  = TIME_LSB + TW;
	localparam int ID_LSB   = MAC_LSB + ntwa_pkg::MAC_W;
	localparam int WORD_W   = ID_LSB + KEY_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                  state_q;
	ntwa_pkg::req_t        req_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  rd_act_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [WORD_W-1:0]     rd_data_s1;
	logic [ENTRIES-1:0]    valid_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  done_q;
	ntwa_pkg::rsp_t        rsp_q;

	// slot memory: one write port, one registered read port
	logic [WORD_W-1:0]     mem [ENTRIES];

	logic                  accept;
	logic                  rd_en;
	logic                  finish;
	logic [ntwa_pkg::STAT_W-1:0] st;
	logic                  pres;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [WORD_W-1:0]     wr_data;
	logic                  set_v;
	logic                  clr_v;
	logic [IDX_W-1:0]      v_idx;
	logic                  nf_found;
	logic [IDX_W-1:0]      nf_idx;
	logic                  slot_v;
	logic                  is_last;
	logic                  id_hit;
	logic                  mac_hit;
	logic [KEY_W-1:0]      key;
	logic [TW-1:0]         tstamp;

	assign busy   = (state_q == S_SCAN);
	assign accept = start && !busy;
	assign rd_en  = busy && rd_act_q;
	assign key    = req_q.node_id[KEY_W-1:0];
	assign tstamp = req_q.contact_time[TW-1:0];

	// compare stage: slot idx_s1 is back from memory
	assign slot_v  = valid_q[idx_s1];
	assign is_last = (idx_s1 == LAST_IDX);
	assign id_hit  = slot_v && (rd_data_s1[ID_LSB +: KEY_W] == key);
	assign mac_hit = slot_v && (rd_data_s1[MAC_LSB +: ntwa_pkg::MAC_W] == req_q.mac);

	always_comb begin
		finish   = 1'b0;
		st       = ntwa_pkg::ST_DONE;
		pres     = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = idx_s1;
		wr_data  = rd_data_s1;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		v_idx    = idx_s1;
		nf_found = free_found_q;
		nf_idx   = free_idx_q;
		if (busy && vld_s1) begin
			case (req_q.func)
				ntwa_pkg::F_INSERT: begin
					// duplicate check runs over every slot before the free slot is used
					if (id_hit) begin
						finish = 1'b1;
						st     = ntwa_pkg::ST_DUP;
					end else begin
						if (!slot_v && !free_found_q) begin
							nf_found = 1'b1;
							nf_idx   = idx_s1;
						end
						if (is_last) begin
							finish = 1'b1;
							if (nf_found) begin
								wr_en   = 1'b1;
								wr_addr = nf_idx;
								wr_data = {key, req_q.mac, tstamp, req_q.connected};
								set_v   = 1'b1;
								v_idx   = nf_idx;
							end else begin
								st = ntwa_pkg::ST_FULL;
							end
						end
					end
				end
				ntwa_pkg::F_ERASE_MAC: begin
					if (mac_hit) begin
						finish = 1'b1;
						clr_v  = 1'b1;
					end else if (is_last) begin
						finish = 1'b1;
						st     = ntwa_pkg::ST_MISS;
					end
				end
				ntwa_pkg::F_ERASE_ID: begin
					if (id_hit) begin
						finish = 1'b1;
						clr_v  = 1'b1;
					end else if (is_last) begin
						finish = 1'b1;
						st     = ntwa_pkg::ST_MISS;
					end
				end
				ntwa_pkg::F_UPDATE: begin
					if (id_hit) begin
						finish  = 1'b1;
						wr_en   = 1'b1;
						wr_data = {rd_data_s1[ID_LSB +: KEY_W],
							rd_data_s1[MAC_LSB +: ntwa_pkg::MAC_W], tstamp, 1'b1};
					end else if (is_last) begin
						finish = 1'b1;
						st     = ntwa_pkg::ST_MISS;
					end
				end
				ntwa_pkg::F_LOOKUP: begin
					if (id_hit) begin
						finish = 1'b1;
						pres   = 1'b1;
					end else if (is_last) begin
						finish = 1'b1;
						st     = ntwa_pkg::ST_MISS;
					end
				end
				ntwa_pkg::F_CLEAR: begin
					// write-back of slot i overlaps the read of slot i+1, no conflict
					if (slot_v) begin
						wr_en   = 1'b1;
						wr_data = {rd_data_s1[WORD_W-1:TIME_LSB], 1'b0};
					end
					finish = is_last;
				end
				ntwa_pkg::F_FLUSH: begin
					clr_v  = slot_v && !rd_data_s1[CONN_LSB];
					finish = is_last;
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	// sequencer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_act_q     <= 1'b0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			valid_q      <= '0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= finish;
			// a hit ends the scan early; the read still in flight is dropped
			vld_s1 <= rd_en && !finish;
			if (set_v) begin
				valid_q[v_idx] <= 1'b1;
			end
			if (clr_v) begin
				valid_q[v_idx] <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_SCAN;
						rd_act_q     <= 1'b1;
						rd_idx_q     <= '0;
						free_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					free_found_q <= nf_found;
					if (finish) begin
						state_q  <= S_IDLE;
						rd_act_q <= 1'b0;
					end else if (rd_act_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_idx_q == LAST_IDX) begin
							rd_act_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1     <= rd_idx_q;
		free_idx_q <= nf_idx;
		if (finish) begin
			rsp_q.status  <= st;
			rsp_q.present <= pres;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// a result only follows a scan
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a scan");

	// an accepted transaction starts a scan
	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accept did not start a scan");

	// duplicate and full status come from inserts only
	a_ins_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ntwa_pkg::ST_DUP || rsp.status == ntwa_pkg::ST_FULL))
		|-> (req_q.func == ntwa_pkg::F_INSERT))
		else $error("insert status on another operation");

	// present only on a successful lookup
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.present) |-> (rsp.status == ntwa_pkg::ST_DONE
			&& req_q.func == ntwa_pkg::F_LOOKUP))
		else $error("present outside a lookup hit");

endmodule
